@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

@@ rtl/rv5s_pkg.sv @@
`default_nettype none
package rv5s_pkg;

   localparam int DataMemBytes = 128;

   localparam logic [6:0] OpcR      = 7'h33;
   localparam logic [6:0] OpcI      = 7'h13;
   localparam logic [6:0] OpcLoad   = 7'h03;
   localparam logic [6:0] OpcStore  = 7'h23;
   localparam logic [6:0] OpcBranch = 7'h63;
   localparam logic [6:0] Funct7Sub = 7'h20;

   localparam logic [2:0] F3Add = 3'd0;
   localparam logic [2:0] F3Sll = 3'd1;
   localparam logic [2:0] F3Slt = 3'd2;
   localparam logic [2:0] F3Beq = 3'd0;
   localparam logic [2:0] F3Blt = 3'd4;

   // Decoded control carried in ID/EX
   typedef struct packed {
      logic        valid;
      logic [6:0]  opcode;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] imm;
      logic        reg_write;
      logic        mem_read;
      logic        mem_write;
   } dex_ctl_type;

   // Execute stage results toward the memory stage
   typedef struct packed {
      logic [31:0] alu;
      logic [31:0] store_data;
      logic [4:0]  rd;
      logic        reg_write;
      logic        mem_read;
      logic        mem_write;
   } exm_type;

   function automatic logic lt_signed(input logic [31:0] x, input logic [31:0] y);
      lt_signed = $signed(x) < $signed(y);
   endfunction

endpackage
`default_nettype wire

@@ rtl/rv32_five_stage_stall_pipeline_unit.sv @@
// An accepted item's result is registered in the output register, or in the skid register while rsp_stall holds it.
// Throughput: one item per cycle while req_stall is low; the whole pipeline tick is one registered pass.
// A one-item skid register absorbs rsp_stall; req_stall rises while it is full or the clear pass runs.
// Reset: pipeline empty, registers zero, PC = 0, then a data-memory clear pass over
// (DATA_MEM_BYTES/4 + 1)/2 words per bank, one per bank each cycle; no item accepted.
`default_nettype none
module rv32_five_stage_stall_pipeline_unit import rv5s_pkg::*; #(
   parameter int DATA_MEM_BYTES = DataMemBytes
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instr_word,
   input  wire logic        req_instr_present,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_fetch_address,
   output logic             rsp_wb_valid,
   output logic [4:0]       rsp_wb_register,
   output logic [31:0]      rsp_wb_value,
   output logic             rsp_hazard_stall,
   output logic             rsp_redirect,
   output logic             rsp_mem_fault,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_start_address
);
   // Memory is word-organized; unaligned accesses span two words.
   localparam int Words = DATA_MEM_BYTES / 4;
   localparam int WAW   = (Words > 1) ? $clog2(Words) : 1;
   localparam int BAW   = $clog2(DATA_MEM_BYTES);
   localparam int Half  = (Words + 1) / 2;
   localparam int HAW   = (Half > 1) ? $clog2(Half) : 1;
   localparam logic [31:0] Limit = 32'(DATA_MEM_BYTES - 4);

   typedef struct packed {
      logic [31:0] fetch_address;
      logic        wb_valid;
      logic [4:0]  wb_register;
      logic [31:0] wb_value;
      logic        hazard_stall;
      logic        redirect;
      logic        mem_fault;
   } rsp_type;

   // Two banks (even/odd word) so an unaligned word touches one word in each.
   logic [31:0] mem_even [Half];
   logic [31:0] mem_odd  [Half];

   logic [31:0] rf [32];
   logic [31:0] pc_ff;
   logic        fd_valid_ff;
   logic [31:0] fd_word_ff, fd_npc_ff;
   dex_ctl_type dc_ff;
   logic [31:0] da_ff, db_ff, dnpc_ff;
   exm_type     em_ff;
   logic        mw_rw_ff, mw_ld_ff;
   logic [4:0]  mw_rd_ff;
   logic [31:0] mw_alu_ff;
   logic [BAW-1:0] mw_off_ff;   // byte offset of the load, for lane select
   logic        mw_ok_ff;
   logic [31:0] ev_rd_ff, od_rd_ff;   // bank read data, captured as the load enters WB
   logic [HAW:0] clr_ff;
   logic [HAW-1:0] clr_idx;
   logic        clr_busy;

   rsp_type out_ff, skid_ff;
   logic    out_v_ff, skid_v_ff;

   logic go;
   assign clr_busy  = (clr_ff != '0);
   assign clr_idx   = HAW'(clr_ff - (HAW+1)'(1));
   assign req_stall = skid_v_ff || clr_busy;
   assign go        = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Writeback
   logic [31:0] ld_data, wb_val;
   logic        wb_v;
   logic [63:0] pair;
   always_comb begin
      pair    = mw_off_ff[2] ? {ev_rd_ff, od_rd_ff} : {od_rd_ff, ev_rd_ff};
      ld_data = mw_ok_ff ? 32'(pair >> {mw_off_ff[1:0], 3'b000}) : '0;
      wb_val  = mw_ld_ff ? ld_data : mw_alu_ff;
      wb_v    = mw_rw_ff && (mw_rd_ff != 5'd0);
   end

   // Execute
   exm_type exm_in;
   logic    taken;
   rv5s_alu u_alu (.ctl(dc_ff), .op_a(da_ff), .op_b(db_ff), .exm(exm_in), .taken(taken));

   // Decode
   dex_ctl_type dec_ctl;
   logic [4:0]  rs1, rs2;
   logic        n1, n2, stall;
   rv5s_decode u_dec (.word(fd_word_ff), .ctl(dec_ctl), .rs1(rs1), .rs2(rs2),
                      .need1(n1), .need2(n2));

   function automatic logic hit(input logic rw, input logic [4:0] r, input logic [4:0] a,
                                input logic [4:0] b, input logic u1, input logic u2);
      hit = rw && (r != 5'd0) && ((u1 && r == a) || (u2 && r == b));
   endfunction

   always_comb begin
      stall = !taken && fd_valid_ff &&
              (hit(dc_ff.reg_write, dc_ff.rd, rs1, rs2, n1, n2) ||
               hit(em_ff.reg_write, em_ff.rd, rs1, rs2, n1, n2) ||
               hit(mw_rw_ff, mw_rd_ff, rs1, rs2, n1, n2));
   end

   // Memory stage addressing
   logic          mem_acc, mem_ok;
   logic [BAW-1:0] boff;
   logic [WAW-1:0] w0, w1;
   always_comb begin
      mem_acc = em_ff.mem_read || em_ff.mem_write;
      mem_ok  = em_ff.alu <= Limit;
      boff    = em_ff.alu[BAW-1:0];
      w0      = boff[BAW-1:2];
      w1      = w0 + WAW'(1);
   end

   logic [31:0] pc_in;
   always_comb begin
      if (taken)
         pc_in = dnpc_ff - 32'd4 + dc_ff.imm;
      else if (!stall && req_instr_present)
         pc_in = pc_ff + 32'd4;
      else
         pc_in = pc_ff;
   end

   // Store lanes: the word is shifted across the two touched words,
   // each byte written through its own enable.
   logic [63:0] st_pair;
   logic [7:0]  st_be;
   logic [31:0] st_lo, st_hi;
   logic [3:0]  be_lo, be_hi;
   logic [HAW-1:0] ix0, ix1;
   always_comb begin
      st_pair = 64'(em_ff.store_data) << {boff[1:0], 3'b000};
      st_be   = 8'(4'hF) << boff[1:0];
      st_lo = st_pair[31:0];  st_hi = st_pair[63:32];
      be_lo = st_be[3:0];     be_hi = st_be[7:4];
      ix0   = HAW'(w0 >> 1);
      ix1   = HAW'(w1 >> 1);
   end

   // Data memory: load read at the edge the item moves into WB, store write
   // at the same edge, clear pass after reset.
   always_ff @(posedge clock) begin
      if (clr_busy) begin
         mem_even[clr_idx] <= '0;
         mem_odd[clr_idx]  <= '0;
      end else if (go && mem_ok) begin
         if (em_ff.mem_read) begin
            ev_rd_ff <= mem_even[w0[0] ? ix1 : ix0];
            od_rd_ff <= mem_odd[w0[0] ? ix0 : ix1];
         end
         if (em_ff.mem_write) begin
            for (int j = 0; j < 4; j++) begin
               if (be_lo[j]) begin
                  if (w0[0]) mem_odd[ix0][8*j +: 8]  <= st_lo[8*j +: 8];
                  else       mem_even[ix0][8*j +: 8] <= st_lo[8*j +: 8];
               end
               if (be_hi[j]) begin
                  if (w0[0]) mem_even[ix1][8*j +: 8] <= st_hi[8*j +: 8];
                  else       mem_odd[ix1][8*j +: 8]  <= st_hi[8*j +: 8];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= (HAW+1)'(Half);
         pc_ff <= '0; fd_valid_ff <= 1'b0; fd_word_ff <= '0; fd_npc_ff <= '0;
         dc_ff <= '0; da_ff <= '0; db_ff <= '0; dnpc_ff <= '0; em_ff <= '0;
         mw_rw_ff <= 1'b0; mw_ld_ff <= 1'b0; mw_rd_ff <= '0; mw_alu_ff <= '0;
         mw_off_ff <= '0; mw_ok_ff <= 1'b0;
         out_v_ff <= 1'b0; skid_v_ff <= 1'b0;
         for (int i = 0; i < 32; i++) rf[i] <= '0;
      end else begin
         if (clr_busy) clr_ff <= clr_ff - (HAW+1)'(1);
         if (csr_valid) pc_ff <= csr_start_address;
         else if (go) pc_ff <= pc_in;
         if (go) begin
            if (wb_v) rf[mw_rd_ff] <= wb_val;
            mw_rw_ff  <= em_ff.reg_write;  mw_ld_ff <= em_ff.mem_read;
            mw_rd_ff  <= em_ff.rd;         mw_alu_ff <= em_ff.alu;
            mw_off_ff <= boff;             mw_ok_ff <= mem_ok;
            em_ff <= exm_in;
            if (taken || stall || !fd_valid_ff) begin
               dc_ff <= '0; da_ff <= '0; db_ff <= '0; dnpc_ff <= '0;
            end else begin
               dc_ff   <= dec_ctl;
               da_ff   <= (wb_v && mw_rd_ff == rs1) ? wb_val : rf[rs1];
               db_ff   <= (wb_v && mw_rd_ff == rs2) ? wb_val : rf[rs2];
               dnpc_ff <= fd_npc_ff;
            end
            if (taken || (!stall && !req_instr_present)) begin
               fd_valid_ff <= 1'b0; fd_word_ff <= '0; fd_npc_ff <= '0;
            end else if (!stall) begin
               fd_valid_ff <= 1'b1; fd_word_ff <= req_instr_word;
               fd_npc_ff <= pc_ff + 32'd4;
            end
         end
         // output + skid
         if (!rsp_stall) begin
            out_v_ff  <= skid_v_ff || go;
            skid_v_ff <= 1'b0;
         end else if (go && out_v_ff) begin
            skid_v_ff <= 1'b1;
         end else if (go) begin
            out_v_ff <= 1'b1;
         end
      end
   end

   // Result of the tick taken at this edge
   rsp_type res;
   always_comb begin
      res.fetch_address = pc_in;
      res.wb_valid      = wb_v;
      res.wb_register   = wb_v ? mw_rd_ff : 5'd0;
      res.wb_value      = wb_v ? wb_val : '0;
      res.hazard_stall  = stall;
      res.redirect      = taken;
      res.mem_fault     = mem_acc && !mem_ok;
   end

   always_ff @(posedge clock) begin
      if (!rsp_stall || !out_v_ff) out_ff <= skid_v_ff ? skid_ff : res;
      if (go && out_v_ff && rsp_stall) skid_ff <= res;
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_fetch_address = out_ff.fetch_address;
   assign rsp_wb_valid      = out_ff.wb_valid;
   assign rsp_wb_register   = out_ff.wb_register;
   assign rsp_wb_value      = out_ff.wb_value;
   assign rsp_hazard_stall  = out_ff.hazard_stall;
   assign rsp_redirect      = out_ff.redirect;
   assign rsp_mem_fault     = out_ff.mem_fault;
endmodule
`default_nettype wire

@@ rtl/rv5s_alu.sv @@
`default_nettype none
module rv5s_alu import rv5s_pkg::*; (
   input  wire dex_ctl_type ctl,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output exm_type          exm,
   output logic             taken
);
   logic [31:0] y;

   always_comb begin
      y = (ctl.opcode == OpcI || ctl.opcode == OpcLoad || ctl.opcode == OpcStore)
          ? ctl.imm : op_b;
      exm.store_data = op_b;
      exm.rd         = ctl.rd;
      exm.reg_write  = ctl.reg_write;
      exm.mem_read   = ctl.mem_read;
      exm.mem_write  = ctl.mem_write;
      exm.alu        = '0;
      taken          = 1'b0;
      if (ctl.valid) begin
         case (ctl.opcode)
            OpcR: begin
               case (ctl.f3)
                  F3Add: exm.alu = (ctl.f7 == Funct7Sub) ? op_a - y : op_a + y;
                  F3Sll: exm.alu = op_a << y[4:0];
                  F3Slt: exm.alu = {31'd0, lt_signed(op_a, y)};
                  default: exm.alu = '0;
               endcase
            end
            OpcI: begin
               case (ctl.f3)
                  F3Add: exm.alu = op_a + y;
                  F3Sll: exm.alu = op_a << y[4:0];
                  default: exm.alu = '0;
               endcase
            end
            OpcLoad, OpcStore: exm.alu = op_a + y;
            OpcBranch: begin
               case (ctl.f3)
                  F3Beq: taken = (op_a == y);
                  F3Blt: taken = lt_signed(op_a, y);
                  default: taken = 1'b0;
               endcase
            end
            default: exm.alu = '0;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/rv5s_decode.sv @@
`default_nettype none
module rv5s_decode import rv5s_pkg::*; (
   input  wire logic [31:0] word,
   output dex_ctl_type      ctl,
   output logic [4:0]       rs1,
   output logic [4:0]       rs2,
   output logic             need1,
   output logic             need2
);
   logic [6:0] op;

   always_comb begin
      op    = word[6:0];
      rs1   = word[19:15];
      rs2   = word[24:20];
      need1 = (op == OpcR) || (op == OpcI) || (op == OpcLoad) ||
              (op == OpcStore) || (op == OpcBranch);
      need2 = (op == OpcR) || (op == OpcStore) || (op == OpcBranch);
      ctl.valid     = 1'b1;
      ctl.opcode    = op;
      ctl.rd        = word[11:7];
      ctl.f3        = word[14:12];
      ctl.f7        = word[31:25];
      ctl.reg_write = (op == OpcR) || (op == OpcI) || (op == OpcLoad);
      ctl.mem_read  = (op == OpcLoad);
      ctl.mem_write = (op == OpcStore);
      unique case (op)
         OpcI, OpcLoad: ctl.imm = {{20{word[31]}}, word[31:20]};
         OpcStore:      ctl.imm = {{20{word[31]}}, word[31:25], word[11:7]};
         OpcBranch:     ctl.imm = {{19{word[31]}}, word[31], word[7], word[30:25],
                                   word[11:8], 1'b0};
         default:       ctl.imm = '0;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/rv5s_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module rv5s_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_wb_valid,
   input wire logic [4:0]  rsp_wb_register,
   input wire logic        rsp_hazard_stall,
   input wire logic        rsp_redirect,
   input wire logic [31:0] rsp_wb_value
);
   `CHK_IMPLY(a_wb_reg, clock, reset, rsp_valid && rsp_wb_valid, rsp_wb_register != 5'd0)
   `CHK_IMPLY(a_wb_zero, clock, reset, rsp_valid && !rsp_wb_valid,
      rsp_wb_register == 5'd0 && rsp_wb_value == 32'd0)
   `CHK_IMPLY(a_excl, clock, reset, rsp_valid && rsp_redirect, !rsp_hazard_stall)
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CHK_NEXT(a_skid, clock, reset, rsp_valid && rsp_stall && req_valid && !req_stall, req_stall)
endmodule

bind rv32_five_stage_stall_pipeline_unit rv5s_checker u_chk (.*);
`default_nettype wire

@@ test/rv32_five_stage_stall_pipeline_unit_tb.sv @@
`default_nettype none
module rv32_five_stage_stall_pipeline_unit_tb import rv5s_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // One tick of the core as seen on the result channel
   typedef struct packed {
      logic [31:0] fetch_address;
      logic        wb_valid;
      logic [4:0]  wb_register;
      logic [31:0] wb_value;
      logic        hazard_stall;
      logic        redirect;
      logic        mem_fault;
   } tick_type;

   // Directed stimulus row; typed expectation only where obvious
   typedef struct {
      logic [31:0] word;
      logic        present;
      logic        typed;
      tick_type    tick;
   } row_type;

   localparam int MemLimit = DataMemBytes - 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_instr_word = '0;
   logic        req_instr_present = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_fetch_address;
   logic        rsp_wb_valid;
   logic [4:0]  rsp_wb_register;
   logic [31:0] rsp_wb_value;
   logic        rsp_hazard_stall;
   logic        rsp_redirect;
   logic        rsp_mem_fault;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_start_address = '0;

   always #1 clock = ~clock;

   rv32_five_stage_stall_pipeline_unit DUT (.*);

   // ---------------------------------------------------------------
   // Core shadow: architectural state plus every pipeline latch
   // ---------------------------------------------------------------
   logic [31:0] regs [32];
   logic [7:0]  dmem [DataMemBytes];
   logic [31:0] pc;
   logic        fd_valid;
   logic [31:0] fd_word, fd_npc;
   logic [31:0] de_a, de_b, de_npc;
   dex_ctl_type de_ctl;
   exm_type     ex_mem;
   logic [31:0] mw_alu, mw_load;
   logic [4:0]  mw_rd;
   logic        mw_write, mw_is_load;

   tick_type expected_ticks [$];
   int n_items, n_ticks, n_errors, n_hazards, n_branches, n_faults, n_writebacks;

   function automatic logic [31:0] sext_i(logic [31:0] w);
      return {{20{w[31]}}, w[31:20]};
   endfunction

   function automatic logic [31:0] sext_s(logic [31:0] w);
      return {{20{w[31]}}, w[31:25], w[11:7]};
   endfunction

   function automatic logic [31:0] sext_b(logic [31:0] w);
      return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   endfunction

   function automatic void core_clear();
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
      {fd_valid, fd_word, fd_npc} = '0;
      {de_a, de_b, de_npc} = '0;
      de_ctl = '0;
      ex_mem = '0;
      {mw_alu, mw_load, mw_rd, mw_write, mw_is_load} = '0;
   endfunction

   // RAW check of one in-flight destination against the decoding word
   function automatic logic raw_hit(logic wr, logic [4:0] r, logic [4:0] rs1, logic [4:0] rs2,
                                    logic n1, logic n2);
      return wr && r != 0 && ((n1 && r == rs1) || (n2 && r == rs2));
   endfunction

   function automatic tick_type core_tick(logic [31:0] word, logic present);
      tick_type    t;
      exm_type     nex;
      dex_ctl_type nctl;
      logic [31:0] nmw_alu, nmw_load, x, y, nde_a, nde_b, nnpc, w, ad;
      logic [4:0]  nmw_rd, rs1, rs2;
      logic [6:0]  op;
      logic        nmw_write, nmw_is_load, n1, n2;
      t = '0;
      // writeback
      if (mw_write && mw_rd != 0) begin
         t.wb_valid = 1'b1;
         t.wb_register = mw_rd;
         t.wb_value = mw_is_load ? mw_load : mw_alu;
         regs[mw_rd] = t.wb_value;
      end
      regs[0] = '0;
      // memory
      nmw_alu = ex_mem.alu;
      nmw_rd = ex_mem.rd;
      nmw_load = '0;
      nmw_write = ex_mem.reg_write;
      nmw_is_load = ex_mem.mem_read;
      if (ex_mem.mem_read || ex_mem.mem_write) begin
         ad = ex_mem.alu;
         if (ad <= MemLimit) begin
            if (ex_mem.mem_read)
               nmw_load = {dmem[ad+3], dmem[ad+2], dmem[ad+1], dmem[ad]};
            else
               {dmem[ad+3], dmem[ad+2], dmem[ad+1], dmem[ad]} = ex_mem.store_data;
         end else begin
            t.mem_fault = 1'b1;
         end
      end
      // execute
      nex = '0;
      nex.store_data = de_b;
      nex.rd = de_ctl.rd;
      nex.reg_write = de_ctl.reg_write;
      nex.mem_read = de_ctl.mem_read;
      nex.mem_write = de_ctl.mem_write;
      if (de_ctl.valid) begin
         x = de_a;
         y = (de_ctl.opcode inside {OpcI, OpcLoad, OpcStore}) ? de_ctl.imm : de_b;
         case (de_ctl.opcode)
            OpcR: begin
               if (de_ctl.f3 == F3Add) nex.alu = (de_ctl.f7 == Funct7Sub) ? x - y : x + y;
               else if (de_ctl.f3 == F3Sll) nex.alu = x << y[4:0];
               else if (de_ctl.f3 == F3Slt) nex.alu = {31'd0, $signed(x) < $signed(y)};
            end
            OpcI: begin
               if (de_ctl.f3 == F3Add) nex.alu = x + y;
               else if (de_ctl.f3 == F3Sll) nex.alu = x << y[4:0];
            end
            OpcLoad, OpcStore: nex.alu = x + y;
            OpcBranch: begin
               if (de_ctl.f3 == F3Beq) t.redirect = (x == y);
               else if (de_ctl.f3 == F3Blt) t.redirect = $signed(x) < $signed(y);
            end
            default: ;
         endcase
      end
      // decode and fetch
      nctl = '0;
      {nde_a, nde_b, nnpc} = '0;
      if (t.redirect) begin
         pc = de_npc - 32'd4 + de_ctl.imm;
         {fd_valid, fd_word, fd_npc} = '0;
      end else begin
         if (fd_valid) begin
            w = fd_word;
            op = w[6:0];
            rs1 = w[19:15];
            rs2 = w[24:20];
            n1 = op inside {OpcR, OpcI, OpcLoad, OpcStore, OpcBranch};
            n2 = op inside {OpcR, OpcStore, OpcBranch};
            t.hazard_stall = raw_hit(de_ctl.reg_write, de_ctl.rd, rs1, rs2, n1, n2) ||
                             raw_hit(ex_mem.reg_write, ex_mem.rd, rs1, rs2, n1, n2) ||
                             raw_hit(mw_write, mw_rd, rs1, rs2, n1, n2);
            if (!t.hazard_stall) begin
               nctl.valid = 1'b1;
               nctl.opcode = op;
               nctl.rd = w[11:7];
               nctl.f3 = w[14:12];
               nctl.f7 = w[31:25];
               nctl.reg_write = op inside {OpcR, OpcI, OpcLoad};
               nctl.mem_read = (op == OpcLoad);
               nctl.mem_write = (op == OpcStore);
               if (op == OpcI || op == OpcLoad) nctl.imm = sext_i(w);
               else if (op == OpcStore) nctl.imm = sext_s(w);
               else if (op == OpcBranch) nctl.imm = sext_b(w);
               nde_a = regs[rs1];
               nde_b = regs[rs2];
               nnpc = fd_npc;
            end
         end
         if (!t.hazard_stall) begin
            if (present) begin
               fd_valid = 1'b1;
               fd_word = word;
               fd_npc = pc + 32'd4;
               pc = pc + 32'd4;
            end else begin
               {fd_valid, fd_word, fd_npc} = '0;
            end
         end
      end
      {mw_alu, mw_load, mw_rd, mw_write, mw_is_load} =
         {nmw_alu, nmw_load, nmw_rd, nmw_write, nmw_is_load};
      ex_mem = nex;
      de_ctl = nctl;
      de_a = nde_a;
      de_b = nde_b;
      de_npc = nnpc;
      t.fetch_address = pc;
      return t;
   endfunction

   // ---------------------------------------------------------------
   // Instruction encoders for the stimulus
   // ---------------------------------------------------------------
   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OpcR};
   endfunction

   function automatic logic [31:0] enc_i(logic [6:0] op, logic [11:0] imm, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
      return {imm[11:5], rs2, rs1, 3'd2, imm[4:0], OpcStore};
   endfunction

   function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OpcBranch};
   endfunction

   // Mostly well-formed code over x0..x7 with data addresses mostly in range,
   // plus a share of raw noise words.
   function automatic logic [31:0] random_instr();
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic [11:0] imm;
      int          kind;
      rd = 5'($urandom_range(1, 7));
      rs1 = 5'($urandom_range(0, 7));
      rs2 = 5'($urandom_range(0, 7));
      kind = $urandom_range(0, 19);
      if (kind < 4) begin
         case ($urandom_range(0, 4))
            0: f3 = F3Add;
            1: f3 = F3Sll;
            2: f3 = F3Slt;
            default: f3 = 3'($urandom);
         endcase
         return enc_r($urandom_range(0, 3) == 0 ? 7'($urandom) :
                      ($urandom_range(0, 1) ? Funct7Sub : 7'd0), rs2, rs1, f3, rd);
      end else if (kind < 8) begin
         imm = $urandom_range(0, 2) == 0 ? 12'($urandom) : 12'($urandom_range(0, 40));
         f3 = $urandom_range(0, 4) == 0 ? 3'($urandom) : ($urandom_range(0, 2) ? F3Add : F3Sll);
         return enc_i(OpcI, imm, kind < 6 ? rs1 : 5'd0, f3, rd);
      end else if (kind < 11) begin
         imm = $urandom_range(0, 9) == 0 ? 12'($urandom) : 12'($urandom_range(0, 127));
         return enc_i(OpcLoad, imm, $urandom_range(0, 3) == 0 ? rs1 : 5'd0, 3'd2, rd);
      end else if (kind < 14) begin
         imm = $urandom_range(0, 9) == 0 ? 12'($urandom) : 12'($urandom_range(0, 127));
         return enc_s(imm, rs2, $urandom_range(0, 3) == 0 ? rs1 : 5'd0);
      end else if (kind < 17) begin
         case ($urandom_range(0, 4))
            0, 1: f3 = F3Beq;
            2, 3: f3 = F3Blt;
            default: f3 = 3'($urandom);
         endcase
         return enc_b($urandom_range(0, 4) == 0 ? 13'($urandom) :
                      13'(2 * ($urandom_range(0, 32) - 16)), rs2, rs1, f3);
      end
      return $urandom;
   endfunction

   // ---------------------------------------------------------------
   // Sender: bursts of random length with random gaps
   // ---------------------------------------------------------------
   int burst_left;

   task automatic send_item(logic [31:0] word, logic present, logic typed, tick_type tick);
      tick_type t;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_instr_word <= word;
      req_instr_present <= present;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      t = core_tick(word, present);
      expected_ticks.push_back(typed ? tick : t);
      n_items++;
      burst_left--;
   endtask

   // Write start_address once the core has drained
   task automatic load_start_address(logic [31:0] value);
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_start_address <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      pc = value;
   endtask

   // ---------------------------------------------------------------
   // Receiver: stall pattern with calm, light and heavy phases
   // ---------------------------------------------------------------
   int stall_mode, stall_phase;

   always @(posedge clock) begin
      tick_type want;
      if (stall_phase == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_phase <= $urandom_range(20, 80);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
      if (!reset && rsp_valid && !rsp_stall) begin
         n_ticks++;
         if (expected_ticks.size() == 0) begin
            $error("result with nothing expected");
            n_errors++;
         end else begin
            want = expected_ticks.pop_front();
            if (rsp_fetch_address !== want.fetch_address) begin
               $error("fetch_address expected %h got %h", want.fetch_address, rsp_fetch_address);
               n_errors++;
            end
            if (rsp_wb_valid !== want.wb_valid) begin
               $error("wb_valid expected %b got %b", want.wb_valid, rsp_wb_valid);
               n_errors++;
            end
            if (rsp_wb_register !== want.wb_register) begin
               $error("wb_register expected %0d got %0d", want.wb_register, rsp_wb_register);
               n_errors++;
            end
            if (rsp_wb_value !== want.wb_value) begin
               $error("wb_value expected %h got %h", want.wb_value, rsp_wb_value);
               n_errors++;
            end
            if (rsp_hazard_stall !== want.hazard_stall) begin
               $error("hazard_stall expected %b got %b", want.hazard_stall, rsp_hazard_stall);
               n_errors++;
            end
            if (rsp_redirect !== want.redirect) begin
               $error("redirect expected %b got %b", want.redirect, rsp_redirect);
               n_errors++;
            end
            if (rsp_mem_fault !== want.mem_fault) begin
               $error("mem_fault expected %b got %b", want.mem_fault, rsp_mem_fault);
               n_errors++;
            end
            n_hazards += want.hazard_stall;
            n_branches += want.redirect;
            n_faults += want.mem_fault;
            n_writebacks += want.wb_valid;
         end
      end
   end

   // Hard stop in case the handshake hangs
   initial begin
      #2_000_000;
      $display("rv32_five_stage_stall_pipeline_unit: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      row_type     rows [$];
      logic [31:0] starts [4];
      int          waited;
      core_clear();
      burst_left = 0;
      // directed program; x1 = -1, x2 = 0x7FF once seeded
      rows = '{
         '{32'h0000_0000, 1'b1, 1'b1, '{32'd4, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0, 1'b0}},
         '{enc_i(OpcI, 12'hFFF, 5'd0, F3Add, 5'd1), 1'b1, 1'b1,
           '{32'd8, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0, 1'b0}},
         '{enc_i(OpcI, 12'h7FF, 5'd0, F3Add, 5'd2), 1'b1, 1'b0, '0},
         '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},                       // absent slot
         '{enc_r(7'd0, 5'd2, 5'd1, F3Add, 5'd3), 1'b1, 1'b0, '0}, // RAW, stalls
         '{32'h0, 1'b0, 1'b0, '0},
         '{32'h0, 1'b0, 1'b0, '0},
         '{32'h0, 1'b0, 1'b0, '0},
         '{enc_r(Funct7Sub, 5'd2, 5'd1, F3Add, 5'd4), 1'b1, 1'b0, '0},
         '{enc_r(7'h7F, 5'd2, 5'd1, F3Sll, 5'd5), 1'b1, 1'b0, '0},
         '{enc_r(Funct7Sub, 5'd2, 5'd1, F3Slt, 5'd6), 1'b1, 1'b0, '0},
         '{enc_i(OpcI, 12'd31, 5'd1, F3Sll, 5'd7), 1'b1, 1'b0, '0},
         '{enc_r(7'd0, 5'd2, 5'd1, 3'd7, 5'd11), 1'b1, 1'b0, '0},  // unknown ALU op
         '{enc_s(12'd8, 5'd2, 5'd0), 1'b1, 1'b0, '0},
         '{enc_i(OpcLoad, 12'd8, 5'd0, 3'd2, 5'd8), 1'b1, 1'b0, '0},
         '{enc_i(OpcLoad, 12'd124, 5'd0, 3'd2, 5'd9), 1'b1, 1'b0, '0},
         '{enc_i(OpcLoad, 12'd125, 5'd0, 3'd2, 5'd10), 1'b1, 1'b0, '0}, // past the end
         '{enc_s(12'hFFC, 5'd2, 5'd0), 1'b1, 1'b0, '0},         // negative address
         '{enc_b(13'd8, 5'd0, 5'd0, F3Beq), 1'b1, 1'b0, '0},
         '{32'hFFFF_FFFF, 1'b1, 1'b0, '0},                       // unknown opcode
         '{enc_b(13'h1FFC, 5'd0, 5'd1, F3Blt), 1'b1, 1'b0, '0},
         '{enc_b(13'd8, 5'd0, 5'd0, 3'd1), 1'b1, 1'b0, '0},      // bogus branch kind
         '{enc_i(OpcI, 12'd5, 5'd1, F3Add, 5'd0), 1'b1, 1'b0, '0}, // write to x0
         '{32'h0, 1'b1, 1'b0, '0},
         '{32'h0, 1'b1, 1'b0, '0}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_start_address(32'h0);
      foreach (rows[i]) send_item(rows[i].word, rows[i].present, rows[i].typed, rows[i].tick);

      // random phases, each from its own start address including the wrap edges
      starts = '{32'hFFFF_FFF8, 32'hFFFF_FFFF, $urandom, 32'h0};
      foreach (starts[p]) begin
         load_start_address(starts[p]);
         repeat (345) begin
            logic [31:0] w;
            w = random_instr();
            send_item(w, $urandom_range(0, 11) != 0, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      waited = 0;
      while (expected_ticks.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      if (expected_ticks.size() != 0)
         $error("%0d results never arrived", expected_ticks.size());
      $display("ran %0d ticks from 5 start addresses, %0d results checked",
               n_items, n_ticks);
      $display("seen: %0d writebacks, %0d RAW bubbles, %0d taken branches, %0d memory faults",
               n_writebacks, n_hazards, n_branches, n_faults);
      if (n_errors == 0 && expected_ticks.size() == 0)
         $display("rv32_five_stage_stall_pipeline_unit: match");
      else
         $display("rv32_five_stage_stall_pipeline_unit: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
